// ===== rtl/core/rmt_pkg.sv =====
// Shared types and constants of the running median tracker.
package rmt_pkg;

    localparam int CAPACITY  = 1024;
    localparam int L_DEPTH   = (CAPACITY + 1) / 2;
    localparam int SIZE_W    = $clog2(L_DEPTH + 1);
    localparam int SAMPLE_W  = 32;
    localparam int CNT_W     = 11;
    localparam int MOD_W     = 15;
    localparam int SUM_W     = 14;
    localparam int DIV_W     = SAMPLE_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(10000);
    localparam logic [MOD_W-1:0] MODULUS_MAX   = MOD_W'(16384);
    localparam logic [MOD_W-1:0] MODULUS_MIN   = MOD_W'(1);

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INS,
        OP_POPINS
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [SAMPLE_W-1:0]   value;
    } t_chain_ctl;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   value;
        logic                  ahead;
    } t_cell_link;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   sample_value;
        logic                  restart;
    } t_in_word;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   median;
        logic [CNT_W-1:0]      sample_count;
        logic [SUM_W-1:0]      median_sum_mod;
        logic                  store_full;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETTLE,
        ST_MOD,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/core/running_median_tracker_top.sv =====
// Top level of the running median tracker.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_stall   | sample_value, restart
//  out     | output    | o_out_valid / i_out_stall | median, sample_count,
//          |           |                           | median_sum_mod, store_full
//  cfg     | input     | i_cfg_we                  | sum_modulus
//
// Once a word is taken, the accepting edge inserts it into the lower and upper cell rows;
// in the settle state the bit-serial remainder starts with the new median, the mod state
// shifts it bit by bit and stores the sum, and the done state loads the output register.
// A dropped word goes from the accepting edge straight to the done state. A new word is
// taken only in the idle state, after the last result is loaded; words never overlap.
// A finished word waits while the output register holds a stalled result; the next word
// can be taken while a result waits. Reset clears counts and sum; no clearing pass.
module running_median_tracker_top import rmt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_word,
    input  logic             i_cfg_we,
    input  logic [MOD_W-1:0] i_cfg_wdata
);

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_count;
    logic [SUM_W-1:0]    r_sum;
    logic [MOD_W-1:0]    r_modulus;
    logic [SAMPLE_W-1:0] r_median;
    logic                r_full;
    logic                r_out_valid;
    t_out_word           r_out;

    logic                w_acc;
    logic                w_load;
    logic                w_start;
    logic [CNT_W-1:0]    w_k;
    logic                w_full;
    logic [SIZE_W-1:0]   w_l_size;
    logic [SIZE_W-1:0]   w_u_size;
    logic [SAMPLE_W-1:0] w_l_head;
    logic [SAMPLE_W-1:0] w_u_head;
    logic [SAMPLE_W-1:0] w_v;
    logic [MOD_W-1:0]    w_mod_eff;
    logic                w_mod_done;
    logic [SUM_W-1:0]    w_mod_rem;
    t_chain_ctl          w_l_ctl;
    t_chain_ctl          w_u_ctl;

    assign w_v      = i_in_word.sample_value;
    assign w_acc    = i_in_valid && !o_in_stall;
    assign w_k      = i_in_word.restart ? '0 : r_count;
    assign w_full   = (w_k == CNT_W'(CAPACITY));
    assign w_l_size = SIZE_W'((w_k + 1'b1) >> 1);
    assign w_u_size = SIZE_W'(w_k >> 1);
    assign w_load   = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        if (r_modulus == '0) begin
            w_mod_eff = MODULUS_MIN;
        end else if (r_modulus > MODULUS_MAX) begin
            w_mod_eff = MODULUS_MAX;
        end else begin
            w_mod_eff = r_modulus;
        end
    end

    // lower row descending from the median, upper row ascending
    always_comb begin
        w_l_ctl = '{op: OP_HOLD, value: w_v};
        w_u_ctl = '{op: OP_HOLD, value: w_v};
        if (w_acc && !w_full) begin
            if (!w_k[0]) begin
                if ((w_k == '0) || (w_v <= w_u_head)) begin
                    w_l_ctl = '{op: OP_INS, value: w_v};
                end else begin
                    w_l_ctl = '{op: OP_INS, value: w_u_head};
                    w_u_ctl = '{op: OP_POPINS, value: w_v};
                end
            end else begin
                if (w_v >= w_l_head) begin
                    w_u_ctl = '{op: OP_INS, value: w_v};
                end else begin
                    w_u_ctl = '{op: OP_INS, value: w_l_head};
                    w_l_ctl = '{op: OP_POPINS, value: w_v};
                end
            end
        end
    end

    rmt_chain u_lower (
        .i_clk  (i_clk),
        .i_ctl  (w_l_ctl),
        .i_desc (1'b1),
        .i_size (w_l_size),
        .o_head (w_l_head)
    );

    rmt_chain u_upper (
        .i_clk  (i_clk),
        .i_ctl  (w_u_ctl),
        .i_desc (1'b0),
        .i_size (w_u_size),
        .o_head (w_u_head)
    );

    rmt_modsum u_modsum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (DIV_W'(r_sum) + DIV_W'(w_l_head)),
        .i_modulus  (w_mod_eff),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_state = w_full ? ST_DONE : ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                n_state = ST_MOD;
            end
            ST_MOD: begin
                if (w_mod_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_start    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_SETTLE: begin
                w_start = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
                w_start    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_modulus   <= MODULUS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
            if (w_acc) begin
                r_count <= w_full ? w_k : w_k + 1'b1;
                if (i_in_word.restart) begin
                    r_sum <= '0;
                end
            end else if (w_mod_done) begin
                r_sum <= w_mod_rem;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_full   <= w_full;
            r_median <= w_l_head;
        end else if (r_state == ST_SETTLE) begin
            r_median <= w_l_head;
        end
        if (w_load) begin
            r_out <= '{median:         r_median,
                       sample_count:   r_count,
                       median_sum_mod: r_sum,
                       store_full:     r_full};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ===== rtl/core/rmt_cell.sv =====
// One compare-and-shift cell of a sorted chain.
module rmt_cell import rmt_pkg::*; (
    input  logic       i_clk,
    input  t_chain_ctl i_ctl,
    input  logic       i_desc,
    input  logic       i_valid,
    input  t_cell_link i_prev,
    input  t_cell_link i_next,
    output t_cell_link o_link
);

    logic [SAMPLE_W-1:0] r_value;
    logic [SAMPLE_W-1:0] n_value;
    logic                w_ahead;

    // ahead: this entry stays ahead of the incoming value
    assign w_ahead = i_valid && (i_desc ? (r_value >= i_ctl.value)
                                        : (r_value <= i_ctl.value));

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            OP_INS: begin
                if (w_ahead) begin
                    n_value = r_value;
                end else if (i_prev.ahead) begin
                    n_value = i_ctl.value;
                end else begin
                    n_value = i_prev.value;
                end
            end
            OP_POPINS: begin
                // head leaves, rest moves toward the head
                if (i_next.ahead) begin
                    n_value = i_next.value;
                end else if (w_ahead) begin
                    n_value = i_ctl.value;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.value = r_value;
    assign o_link.ahead = w_ahead;

endmodule

// ===== rtl/core/rmt_chain.sv =====
// Row of sorted cells with its head value brought out.
module rmt_chain import rmt_pkg::*; (
    input  logic                i_clk,
    input  t_chain_ctl          i_ctl,
    input  logic                i_desc,
    input  logic [SIZE_W-1:0]   i_size,
    output logic [SAMPLE_W-1:0] o_head
);

    t_cell_link w_link [L_DEPTH];
    t_cell_link w_prev [L_DEPTH];
    t_cell_link w_next [L_DEPTH];

    for (genvar i = 0; i < L_DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign w_prev[i] = '{value: '0, ahead: 1'b1};
        end else begin : g_mid
            assign w_prev[i] = w_link[i-1];
        end
        if (i == L_DEPTH - 1) begin : g_last
            assign w_next[i] = '{value: '0, ahead: 1'b0};
        end else begin : g_inner
            assign w_next[i] = w_link[i+1];
        end

        rmt_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_desc  (i_desc),
            .i_valid (i_size > SIZE_W'(i)),
            .i_prev  (w_prev[i]),
            .i_next  (w_next[i]),
            .o_link  (w_link[i])
        );
    end

    assign o_head = w_link[0].value;

endmodule

// ===== rtl/core/rmt_modsum.sv =====
// Bit-serial remainder of the running median sum.
module rmt_modsum import rmt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [MOD_W-1:0] i_modulus,
    output logic             o_done,
    output logic [SUM_W-1:0] o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_shift;
    logic [SUM_W-1:0]     r_rem;
    logic [MOD_W-1:0]     r_mod;
    logic [MOD_W-1:0]     w_trial;
    logic [SUM_W-1:0]     w_rem;

    assign w_trial = {r_rem, r_shift[DIV_W-1]};
    assign w_rem   = (w_trial >= r_mod) ? SUM_W'(w_trial - r_mod) : SUM_W'(w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
            r_mod   <= i_modulus;
        end else if (r_busy) begin
            r_shift <= {r_shift[DIV_W-2:0], 1'b0};
            r_rem   <= w_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/core/rmt_checker.sv =====
// Port-level checks of the running median tracker and their binding.
module rmt_checker import rmt_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input t_out_word        o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("out word changed while stalled");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.store_full |->
            o_out_word.sample_count == CNT_W'(CAPACITY))
        else $error("store full reported below capacity");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.sample_count != '0)
        else $error("result with empty store");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while one is in work");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("out valid after reset");

endmodule

bind running_median_tracker_top rmt_checker u_rmt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
